>>> sv/utf8_to_utf16_decoder_assert.svh
// Assertion macros for the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U8U16_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8u16 same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8u16 next-cycle check failed");

`endif

>>> sv/u8u16_pkg.sv
// Types, codes and constants shared by the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int OUT_COUNT_W     = 32;
   localparam int ACC_W           = 21;
   localparam int UNIT_W          = 16;

   // Automaton codes; ST_END is only ever a next-state result.
   localparam logic [2:0] ST_END      = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_ONE_MORE = 3'd2;
   localparam logic [2:0] ST_TWO_MORE = 3'd3;
   localparam logic [2:0] ST_HDR2     = 3'd4;
   localparam logic [2:0] ST_HDR3     = 3'd5;
   localparam logic [2:0] ST_HDR4     = 3'd6;

   localparam logic [7:0] MASK_CONT = 8'b0011_1111;
   localparam logic [7:0] MASK_HDR2 = 8'b0001_1111;
   localparam logic [7:0] MASK_HDR3 = 8'b0000_1111;
   localparam logic [7:0] MASK_HDR4 = 8'b0000_0111;

   typedef struct packed {
      logic             skipping;
      logic [2:0]       state;
      logic [ACC_W-1:0] acc;
   } dec_state_type;

   typedef struct packed {
      logic                   valid;
      logic [UNIT_W-1:0]      code_unit;
      logic                   done_res;
      logic                   ok;
      logic [OUT_COUNT_W-1:0] char_count;
   } dec_result_type;

endpackage

`default_nettype wire

>>> sv/u8u16_next.sv
// Next-state and result logic of the UTF-8 decoding automaton for one byte.
`default_nettype none

module u8u16_next
   import u8u16_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  dec_state_type          cur,
   input  logic [COUNT_WIDTH-1:0] cnt,
   input  logic [7:0]             in_byte,
   output dec_state_type          nxt,
   output logic [COUNT_WIDTH-1:0] cnt_next,
   output dec_result_type         res
);

   logic                   cont;
   logic [2:0]             last;
   logic [2:0]             nx;
   logic [ACC_W-1:0]       acc_shift;
   logic [ACC_W-1:0]       cp;
   logic [OUT_COUNT_W-1:0] count_sat;
   logic                   good;

   if (COUNT_WIDTH > OUT_COUNT_W) begin : g_wide
      assign count_sat = (|cnt[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1 : cnt[OUT_COUNT_W-1:0];
   end else begin : g_narrow
      assign count_sat = OUT_COUNT_W'(cnt);
   end

   assign cont      = (in_byte[7:6] == 2'b10);
   // unused codes fall back to idle
   assign last      = (cur.state inside {[ST_IDLE:ST_HDR4]}) ? cur.state : ST_IDLE;
   assign acc_shift = {cur.acc[ACC_W-7:0], in_byte[5:0]};
   assign cp        = (last == ST_IDLE) ? ACC_W'(in_byte) : acc_shift;
   assign good      = (in_byte == 8'd0) && (last == ST_IDLE);

   always_comb begin
      case (last)
         ST_ONE_MORE, ST_HDR2: nx = cont ? ST_IDLE : ST_END;
         ST_TWO_MORE, ST_HDR3: nx = cont ? ST_ONE_MORE : ST_END;
         ST_HDR4:              nx = cont ? ST_TWO_MORE : ST_END;
         default: begin
            if (in_byte != 8'd0 && !in_byte[7])  nx = ST_IDLE;
            else if (in_byte[7:5] == 3'b110)     nx = ST_HDR2;
            else if (in_byte[7:4] == 4'b1110)    nx = ST_HDR3;
            else if (in_byte[7:3] == 5'b11110)   nx = ST_HDR4;
            else                                 nx = ST_END;
         end
      endcase
   end

   always_comb begin
      nxt      = cur;
      cnt_next = cnt;
      res      = '0;
      if (cur.skipping) begin
         // dropping bytes until the terminating NUL
         if (in_byte == 8'd0) begin
            nxt      = '{skipping: 1'b0, state: ST_IDLE, acc: '0};
            cnt_next = '0;
         end
      end else begin
         nxt.state = nx;
         case (nx)
            ST_END: begin
               res.valid      = 1'b1;
               res.done_res   = 1'b1;
               res.ok         = good;
               res.char_count = good ? count_sat : '0;
               nxt            = '{skipping: (in_byte != 8'd0), state: ST_IDLE, acc: '0};
               cnt_next       = '0;
            end
            ST_IDLE: begin
               nxt.acc       = cp;
               res.valid     = 1'b1;
               res.code_unit = cp[UNIT_W-1:0];
               if (cnt != '1) cnt_next = cnt + 1'b1;
            end
            ST_ONE_MORE, ST_TWO_MORE: nxt.acc = acc_shift;
            ST_HDR2: nxt.acc = ACC_W'(in_byte & MASK_HDR2);
            ST_HDR3: nxt.acc = ACC_W'(in_byte & MASK_HDR3);
            default: nxt.acc = ACC_W'(in_byte & MASK_HDR4);
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder: byte register, automaton, result register.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_in_byte[7:0]
//   rsp      out  rsp_valid/rsp_ready   rsp_code_unit[15:0], rsp_done_res, rsp_ok,
//                                       rsp_char_count[31:0]
//
// One byte per cycle unless a stalled result holds the byte register; a byte is
// captured in the byte register and its result is then registered in the result register.
// The automaton update (table decode plus shift-or) sits between the byte
// register and the result register. A stalled result only holds the byte
// register when that byte would give a result. Synchronous reset returns the
// automaton to idle with an empty accumulator and a zero count.
`default_nettype none

module utf8_to_utf16_decoder
   import u8u16_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [UNIT_W-1:0]      rsp_code_unit,
   output logic                   rsp_done_res,
   output logic                   rsp_ok,
   output logic [OUT_COUNT_W-1:0] rsp_char_count
);

`include "utf8_to_utf16_decoder_assert.svh"

   dec_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   dec_result_type         out_ff;
   dec_result_type         res;
   logic                   advance;

   u8u16_next #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_next (
      .cur      (state_ff),
      .cnt      (cnt_ff),
      .in_byte  (in_byte_ff),
      .nxt      (state_in),
      .cnt_next (cnt_in),
      .res      (res)
   );

   // bytes without a result pass even while the result register is full
   assign advance   = in_valid_ff && (!res.valid || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance && res.valid) out_valid_in = 1'b1;
      else if (rsp_ready)       out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{skipping: 1'b0, state: ST_IDLE, acc: '0};
         cnt_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_in_byte;
      if (advance && res.valid)   out_ff     <= res;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_unit  = out_ff.code_unit;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_ok         = out_ff.ok;
   assign rsp_char_count = out_ff.char_count;

   `U8U16_ASSERT_IMPLY(a_end_no_unit, clock, reset, rsp_valid && rsp_done_res, rsp_code_unit == '0)
   `U8U16_ASSERT_IMPLY(a_char_no_status, clock, reset, rsp_valid && !rsp_done_res, !rsp_ok && rsp_char_count == '0)
   `U8U16_ASSERT_IMPLY(a_skip_restarted, clock, reset, state_ff.skipping, state_ff.state == ST_IDLE && state_ff.acc == '0 && cnt_ff == '0)
   `U8U16_ASSERT_NEXT(a_byte_held, clock, reset, in_valid_ff && !req_ready, in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
